FILE: hdl/prr_pkg.sv
// Shared constants and types for the polyphase rational resampler.
// Used by prr_mac and polyphase_rational_resampler; no dependencies.

package prr_pkg;

    localparam int MAX_TAPS  = 1024;
    localparam int ADDR_W    = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W = ADDR_W + 1;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int UP_W      = 7;
    localparam int DOWN_W    = 8;
    localparam int PHASE_W   = 9;
    localparam int UP_CAP    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_FACTOR   = 2'd0,
        REG_DOWN_FACTOR = 2'd1,
        REG_TAP_COUNT   = 2'd2,
        REG_APPLY_GAIN  = 2'd3
    } cfg_reg_t;

    // Tag that travels with each memory read into the MAC.
    typedef struct packed {
        logic vld;      // a slot of the MAC stream (tap or empty end marker)
        logic tap;      // slot carries a real tap
        logic hist_ok;  // history entry has been written since reset
        logic tap_end;  // final slot of this output
    } mac_tag_t;

    typedef struct packed {
        logic                vld;
        logic                overflow;
        logic [SAMPLE_W-1:0] value;
    } mac_res_t;

endpackage

FILE: hdl/prr_mac.sv
// Multiply-accumulate datapath: product, saturating accumulate, optional gain, round.
// Depends on prr_pkg for widths and the tag and result structs.

module prr_mac
    import prr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mac_tag_t            tag,
    input  logic [COEF_W-1:0]   coef_data,
    input  logic [SAMPLE_W-1:0] hist_data,
    input  logic [UP_W-1:0]     up,
    input  logic                apply_gain,
    input  logic                take,
    output mac_res_t            res
);

    localparam int SHIFT   = COEF_W - 1;
    localparam int RND_W   = ACC_W - SHIFT + 1;
    localparam int GPROD_W = ACC_W + UP_W + 1;

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       c_vld_reg;
    logic                       c_end_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       acc_sat_reg;
    logic signed [ACC_W-1:0]    fin_reg;
    logic                       fin_sat_reg;
    logic                       fin_vld_reg;
    logic signed [ACC_W-1:0]    g_reg;
    logic                       g_sat_reg;
    logic                       g_vld_reg;
    mac_res_t                   res_reg;

    logic signed [COEF_W-1:0]   coef_eff;
    logic signed [SAMPLE_W-1:0] hist_eff;
    logic signed [ACC_W:0]      sum;
    logic signed [ACC_W-1:0]    sum_sat;
    logic                       sum_ovf;
    logic signed [GPROD_W-1:0]  gprod;
    logic signed [ACC_W-1:0]    gain_val;
    logic                       gain_ovf;
    logic signed [RND_W-1:0]    rnd;
    logic                       rnd_ovf;
    logic [SAMPLE_W-1:0]        rnd_val;

    // An empty slot contributes zero whatever its coefficient entry holds, and a
    // never-written history entry contributes zero as well.
    assign coef_eff = tag.tap ? $signed(coef_data) : '0;
    assign hist_eff = (tag.tap && tag.hist_ok) ? $signed(hist_data) : '0;

    always_comb
    begin
        sum = {acc_reg[ACC_W-1], acc_reg}
            + {{(ACC_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        sum_ovf = sum[ACC_W] != sum[ACC_W-1];
        if (sum_ovf)
        begin
            sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[ACC_W-1:0];
        end
    end

    always_comb
    begin
        gprod = {{(UP_W+1){fin_reg[ACC_W-1]}}, fin_reg} * $signed({{ACC_W{1'b0}}, 1'b0, up});
        gain_ovf = 1'b0;
        gain_val = fin_reg;
        if (apply_gain)
        begin
            gain_ovf = gprod[GPROD_W-1:ACC_W-1] != {(UP_W+2){gprod[GPROD_W-1]}};
            if (gain_ovf)
            begin
                gain_val = gprod[GPROD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                            : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                gain_val = gprod[ACC_W-1:0];
            end
        end
    end

    // Round half up: floor of the shift plus the highest bit dropped.
    always_comb
    begin
        rnd = {g_reg[ACC_W-1], g_reg[ACC_W-1:SHIFT]} + {{(RND_W-1){1'b0}}, g_reg[SHIFT-1]};
        rnd_ovf = rnd[RND_W-1:SAMPLE_W-1] != {(RND_W-SAMPLE_W+1){rnd[RND_W-1]}};
        if (rnd_ovf)
        begin
            rnd_val = rnd[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            rnd_val = rnd[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_eff * hist_eff;
        if (c_vld_reg && c_end_reg)
        begin
            fin_reg <= sum_sat;
        end
        if (fin_vld_reg)
        begin
            g_reg <= gain_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg   <= 1'b0;
            c_end_reg   <= 1'b0;
            acc_reg     <= '0;
            acc_sat_reg <= 1'b0;
            fin_sat_reg <= 1'b0;
            fin_vld_reg <= 1'b0;
            g_sat_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            c_vld_reg   <= tag.vld;
            c_end_reg   <= tag.tap_end;
            fin_vld_reg <= c_vld_reg && c_end_reg;
            if (c_vld_reg)
            begin
                if (c_end_reg)
                begin
                    fin_sat_reg <= acc_sat_reg | sum_ovf;
                    acc_reg     <= '0;
                    acc_sat_reg <= 1'b0;
                end
                else
                begin
                    acc_reg     <= sum_sat;
                    acc_sat_reg <= acc_sat_reg | sum_ovf;
                end
            end
            g_vld_reg <= fin_vld_reg;
            if (fin_vld_reg)
            begin
                g_sat_reg <= fin_sat_reg | gain_ovf;
            end
            if (g_vld_reg)
            begin
                res_reg.vld      <= 1'b1;
                res_reg.overflow <= g_sat_reg | rnd_ovf;
                res_reg.value    <= rnd_val;
            end
            else if (take)
            begin
                res_reg.vld <= 1'b0;
            end
        end
    end

    assign res = res_reg;

endmodule

FILE: hdl/polyphase_rational_resampler.sv
// Top level of the polyphase rational resampler: memories, sequencer, output.
// Depends on prr_pkg and prr_mac.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_stall    cmd, sample, coef_index, coef_value
//   out      out        out_valid/out_stall  out_sample, overflow, last
//
// A coefficient write or a sample that yields no output leaves the sequencer idle.
// Each output walks its polyphase branch through the one shared MAC, one tap a
// cycle from the coefficient and history memories, ceil((taps - p) / up) slots
// (at least one); the pipeline drains before the sample's next output starts.
// Reset leaves the history reading as zero through a fill count; no clearing pass.
// A stalled output holds the sequencer before it hands over the next result.

module polyphase_rational_resampler
    import prr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic [ADDR_W-1:0]     coef_index,
    input  logic [COEF_W-1:0]     coef_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SAMPLE_W-1:0]   out_sample,
    output logic                  overflow,
    output logic                  last
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } state_t;

    logic [COEF_W-1:0]   coef_mem [MAX_TAPS];
    logic [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic [COEF_W-1:0]   coef_rd_reg;
    logic [SAMPLE_W-1:0] hist_rd_reg;

    state_t               state_reg, state_next;
    logic [UP_W-1:0]      up_factor_reg;
    logic [DOWN_W-1:0]    down_factor_reg;
    logic [TAP_CNT_W-1:0] tap_count_reg;
    logic                 apply_gain_reg;
    logic [ADDR_W-1:0]    wp_reg, wp_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [TAP_CNT_W-1:0] fill_reg, fill_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [PHASE_W-1:0]   p_reg, p_next;
    logic [TAP_CNT_W-1:0] t_reg, t_next;
    logic [ADDR_W-1:0]    k_reg, k_next;
    mac_tag_t             tag_reg, tag_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_sample_reg;
    logic                 overflow_reg;
    logic                 last_reg;

    logic [UP_W-1:0]      up_c;
    logic [DOWN_W-1:0]    down_c;
    logic [TAP_CNT_W-1:0] taps_c;
    logic                 in_acc;
    logic                 coef_we;
    logic                 hist_we;
    logic [TAP_CNT_W-1:0] t_step;
    logic [PHASE_W:0]     p_adv;
    logic                 out_free;
    logic                 load_out;
    logic                 final_out;
    mac_res_t             mac_res;

    assign up_c   = (up_factor_reg == '0) ? UP_W'(1)
                  : ((up_factor_reg > UP_W'(UP_CAP)) ? UP_W'(UP_CAP) : up_factor_reg);
    assign down_c = (down_factor_reg == '0) ? DOWN_W'(1) : down_factor_reg;
    assign taps_c = (tap_count_reg > TAP_CNT_W'(MAX_TAPS)) ? TAP_CNT_W'(MAX_TAPS)
                                                           : tap_count_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = state_reg != ST_IDLE;
    assign in_acc    = in_valid && !in_stall;
    assign coef_we   = in_acc && cmd;
    assign hist_we   = in_acc && !cmd;

    assign t_step    = t_reg + TAP_CNT_W'(up_c);
    assign p_adv     = {1'b0, p_reg} + (PHASE_W+1)'(down_c);
    assign final_out = p_adv >= (PHASE_W+1)'(up_c);
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = (state_reg == ST_WAIT) && mac_res.vld && out_free;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        tag_next       = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (hist_we)
                begin
                    base_next = wp_reg;
                    wp_next   = wp_reg + ADDR_W'(1);
                    if (fill_reg != TAP_CNT_W'(MAX_TAPS))
                    begin
                        fill_next = fill_reg + TAP_CNT_W'(1);
                    end
                    if (phase_reg < PHASE_W'(up_c))
                    begin
                        p_next     = phase_reg;
                        t_next     = TAP_CNT_W'(phase_reg);
                        k_next     = '0;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        phase_next = phase_reg - PHASE_W'(up_c);
                    end
                end
            end
            ST_ISSUE:
            begin
                // A phase beyond the tap count still sends one empty end slot.
                tag_next.vld     = 1'b1;
                tag_next.tap     = t_reg < taps_c;
                tag_next.hist_ok = TAP_CNT_W'(k_reg) < fill_reg;
                tag_next.tap_end = !(t_step < taps_c);
                t_next = t_step;
                k_next = k_reg + ADDR_W'(1);
                if (tag_next.tap_end)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (final_out)
                    begin
                        phase_next = PHASE_W'(p_adv - (PHASE_W+1)'(up_c));
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        p_next     = p_adv[PHASE_W-1:0];
                        t_next     = TAP_CNT_W'(p_adv);
                        k_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_index] <= coef_value;
        end
        coef_rd_reg <= coef_mem[t_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wp_reg] <= sample;
        end
        hist_rd_reg <= hist_mem[base_reg - k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sample_reg <= mac_res.value;
            overflow_reg   <= mac_res.overflow;
            last_reg       <= final_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            up_factor_reg   <= UP_W'(1);
            down_factor_reg <= DOWN_W'(1);
            tap_count_reg   <= TAP_CNT_W'(1);
            apply_gain_reg  <= 1'b1;
            wp_reg          <= '0;
            base_reg        <= '0;
            fill_reg        <= '0;
            phase_reg       <= '0;
            p_reg           <= '0;
            t_reg           <= '0;
            k_reg           <= '0;
            tag_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            base_reg      <= base_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            p_reg         <= p_next;
            t_reg         <= t_next;
            k_reg         <= k_next;
            tag_reg       <= tag_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_UP_FACTOR:   up_factor_reg   <= cfg_data[UP_W-1:0];
                    REG_DOWN_FACTOR: down_factor_reg <= cfg_data[DOWN_W-1:0];
                    REG_TAP_COUNT:   tap_count_reg   <= cfg_data[TAP_CNT_W-1:0];
                    REG_APPLY_GAIN:  apply_gain_reg  <= cfg_data[0];
                    default:         apply_gain_reg  <= apply_gain_reg;
                endcase
            end
        end
    end

    prr_mac u_mac
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag_reg),
        .coef_data  (coef_rd_reg),
        .hist_data  (hist_rd_reg),
        .up         (up_c),
        .apply_gain (apply_gain_reg),
        .take       (load_out),
        .res        (mac_res)
    );

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign overflow   = overflow_reg;
    assign last       = last_reg;

endmodule

FILE: tb/tb_polyphase_rational_resampler.sv
// Self-checking testbench for polyphase_rational_resampler: a predictor of the
// resampler checks every output transaction. Depends on prr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_polyphase_rational_resampler;
    import prr_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 120;

    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint OUT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_LO = -OUT_HI - 1;

    typedef struct packed {
        logic                is_coef;
        logic [SAMPLE_W-1:0] smp;
        logic [ADDR_W-1:0]   addr;
        logic [COEF_W-1:0]   val;
    } feed_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                overflow;
        logic                last;
    } resampled_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_UP_FACTOR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cmd = 1'b0;
    logic [SAMPLE_W-1:0]   sample = '0;
    logic [ADDR_W-1:0]     coef_index = '0;
    logic [COEF_W-1:0]     coef_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   out_sample;
    logic                  overflow;
    logic                  last;

    // Shadow of the block's state and registers.
    logic signed [COEF_W-1:0]   coef_m [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] hist_m [MAX_TAPS];
    int unsigned                wr_ptr_m = 0;
    int unsigned                phase_m = 0;
    logic [UP_W-1:0]            up_cfg = 1;
    logic [DOWN_W-1:0]          down_cfg = 1;
    logic [TAP_CNT_W-1:0]       taps_cfg = 1;
    logic                       gain_cfg = 1'b1;

    feed_t       feed_q[$];
    resampled_t  resampled_q[$];
    int unsigned queued_cnt = 0;
    int unsigned taken_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          failed = 1'b0;
    bit          steady = 1'b0;
    bit          hold_go = 1'b0;
    bit          rx_hold_off = 1'b0;

    polyphase_rational_resampler u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .sample     (sample),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .overflow   (overflow),
        .last       (last)
    );

    always #10 clk = ~clk;

    function automatic longint clamp_acc(input longint v, inout bit clipped);
        if (v > ACC_HI)
        begin
            clipped = 1'b1;
            return ACC_HI;
        end
        if (v < ACC_LO)
        begin
            clipped = 1'b1;
            return ACC_LO;
        end
        return v;
    endfunction

    // Works out every output that one accepted transaction causes.
    task automatic resample_item(input logic is_coef, input logic [SAMPLE_W-1:0] smp,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic [COEF_W-1:0] val);
        int unsigned up, down, taps, p, t, k, slot;
        longint      acc, q;
        bit          clipped;
        resampled_t  res;
        if (is_coef)
        begin
            coef_m[addr] = val;
        end
        else
        begin
            hist_m[wr_ptr_m] = smp;
            up = (up_cfg == 0) ? 1 : ((int'(up_cfg) > UP_CAP) ? UP_CAP : int'(up_cfg));
            down = (down_cfg == 0) ? 1 : int'(down_cfg);
            taps = (int'(taps_cfg) > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
            p = phase_m;
            while (p < up)
            begin
                acc = 0;
                clipped = 1'b0;
                k = 0;
                for (t = p; t < taps; t += up)
                begin
                    slot = (wr_ptr_m + MAX_TAPS - k) % MAX_TAPS;
                    acc = clamp_acc(acc + longint'(coef_m[t]) * longint'(hist_m[slot]),
                                    clipped);
                    k++;
                end
                if (gain_cfg)
                    acc = clamp_acc(acc * longint'(up), clipped);
                // Round half up: floor of the shift plus the highest dropped bit.
                q = (acc >>> (COEF_W - 1)) + longint'(acc[COEF_W-2]);
                if (q > OUT_HI)
                begin
                    q = OUT_HI;
                    clipped = 1'b1;
                end
                else if (q < OUT_LO)
                begin
                    q = OUT_LO;
                    clipped = 1'b1;
                end
                res.value = q[SAMPLE_W-1:0];
                res.overflow = clipped;
                res.last = (p + down >= up);
                resampled_q.push_back(res);
                p += down;
            end
            phase_m = (p - up) & 32'h1FF;
            wr_ptr_m = (wr_ptr_m + 1) % MAX_TAPS;
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        bit [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
            2: return {{(SAMPLE_W-8){r[7]}}, r[7:0]};
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        bit [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return {1'b0, {(COEF_W-1){1'b1}}};
            1: return {1'b1, {(COEF_W-1){1'b0}}};
            2: return {{(COEF_W-10){r[9]}}, r[9:0]};
            default: return r[COEF_W-1:0];
        endcase
    endfunction

    task automatic queue_sample(input logic [SAMPLE_W-1:0] smp);
        feed_t f;
        f = '{is_coef: 1'b0, smp: smp, addr: '0, val: '0};
        feed_q.push_back(f);
        queued_cnt++;
    endtask

    task automatic queue_coef(input logic [ADDR_W-1:0] addr, input logic [COEF_W-1:0] val);
        feed_t f;
        f.is_coef = 1'b1;
        f.smp = pick_sample();
        f.addr = addr;
        f.val = val;
        feed_q.push_back(f);
        queued_cnt++;
    endtask

    // Returns once every transaction has gone in and every output has come out.
    task automatic wait_idle();
        while (taken_cnt != queued_cnt || resampled_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_UP_FACTOR:   up_cfg = data[UP_W-1:0];
            REG_DOWN_FACTOR: down_cfg = data[DOWN_W-1:0];
            REG_TAP_COUNT:   taps_cfg = data[TAP_CNT_W-1:0];
            REG_APPLY_GAIN:  gain_cfg = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int unsigned up, input int unsigned down,
                              input int unsigned taps, input int unsigned gain);
        wait_idle();
        write_reg(REG_UP_FACTOR, CFG_DATA_W'(up));
        write_reg(REG_DOWN_FACTOR, CFG_DATA_W'(down));
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
        write_reg(REG_APPLY_GAIN, CFG_DATA_W'(gain));
    endtask

    // Sender: a held transaction stays put until the block takes it.
    always @(posedge clk)
    begin : feeder
        feed_t f;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                resample_item(cmd, sample, coef_index, coef_value);
                taken_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (feed_q.size() != 0 && (steady || $urandom_range(0, 99) >= 10))
                begin
                    f = feed_q.pop_front();
                    in_valid <= 1'b1;
                    cmd <= f.is_coef;
                    sample <= f.smp;
                    coef_index <= f.addr;
                    coef_value <= f.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        resampled_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (resampled_q.size() == 0)
                begin
                    $error("output transaction with none expected: out_sample %0d",
                           $signed(out_sample));
                    failed = 1'b1;
                end
                else
                begin
                    want = resampled_q.pop_front();
                    if (out_sample !== want.value)
                    begin
                        $error("out_sample: expected %0d, actual %0d",
                               $signed(want.value), $signed(out_sample));
                        failed = 1'b1;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
                        failed = 1'b1;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, last);
                        failed = 1'b1;
                    end
                end
            end
            out_stall <= rx_hold_off || (!steady && $urandom_range(0, 99) < 10);
        end
    end

    // Holds the output off long enough for the block to back up into its input.
    initial
    begin : rx_hold
        wait (hold_go);
        @(posedge clk);
        rx_hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned up, down, n, rnd_cnt;
        bit          first;
        bit [31:0]   r;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            coef_m[i] = '0;
            hist_m[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings use a single tap, so only coefficient zero is read.
        queue_coef('0, {1'b0, {(COEF_W-1){1'b1}}});
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_coef('0, {1'b1, {(COEF_W-1){1'b0}}});
        queue_sample(16'h8000);
        queue_sample(16'h7FFF);
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'h0001);

        // Decimating past the branch count leaves some samples without outputs.
        set_config(3, 5, 1, 0);
        repeat (6) queue_sample(pick_sample());

        // Coefficients read by the later settings: the first 128 entries and
        // every 64th entry up to the top of the memory.
        for (int i = 0; i < 128; i++)
        begin
            r = i;
            queue_coef(r[ADDR_W-1:0], pick_coef());
        end
        for (int i = 128; i < MAX_TAPS; i += 64)
        begin
            r = i;
            queue_coef(r[ADDR_W-1:0], pick_coef());
        end

        set_config(64, 255, 64, 1);
        repeat (12) queue_sample(pick_sample());
        // Upper register bits set: up and taps clip to their caps, and a decimation
        // of 64 keeps every output on branch zero.
        set_config(11'h7FF, 11'h740, 11'h7FF, 11'h7FF);
        repeat (6) queue_sample(pick_sample());
        set_config(1, 1, 128, 1);
        repeat (3) queue_sample(pick_sample());
        set_config(0, 0, 0, 1);
        repeat (4) queue_sample(pick_sample());
        set_config(64, 1, 64, 11'h7FE);
        hold_go = 1'b1;
        repeat (3) queue_sample(pick_sample());

        rnd_cnt = 0;
        first = 1'b1;
        while (rnd_cnt < RANDOM_ITEMS)
        begin
            up = $urandom_range(1, 8);
            down = $urandom_range(1, 2 * up + 1);
            set_config(up, down, $urandom_range(1, 48), $urandom_range(0, 1));
            steady <= first;
            first = 1'b0;
            n = $urandom_range(20, 40);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    r = $urandom;
                    queue_coef(r[ADDR_W-1:0], pick_coef());
                end
                else
                begin
                    queue_sample(pick_sample());
                end
                rnd_cnt++;
            end
        end

        wait_idle();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
